### rtl/core/mseu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mseu_pkg
// Opcodes, syscall codes and the shared result record of the MIPS subset
// execute unit.
// ----------------------------------------------------------------------------
package mseu_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 5;
    localparam int unsigned OP_W   = 4;
    localparam int unsigned IMM_W  = 16;
    localparam int unsigned EV_W   = 3;
    localparam int unsigned NUM_REGS = 32;

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD     = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB     = 4'd1;
    localparam logic [OP_W-1:0] OP_AND     = 4'd2;
    localparam logic [OP_W-1:0] OP_OR      = 4'd3;
    localparam logic [OP_W-1:0] OP_SLT     = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL     = 4'd5;
    localparam logic [OP_W-1:0] OP_BEQ     = 4'd6;
    localparam logic [OP_W-1:0] OP_BNE     = 4'd7;
    localparam logic [OP_W-1:0] OP_ADDI    = 4'd8;
    localparam logic [OP_W-1:0] OP_SLTI    = 4'd9;
    localparam logic [OP_W-1:0] OP_ANDI    = 4'd10;
    localparam logic [OP_W-1:0] OP_ORI     = 4'd11;
    localparam logic [OP_W-1:0] OP_LUI     = 4'd12;
    localparam logic [OP_W-1:0] OP_SYSCALL = 4'd13;

    // fixed registers: register zero and the two read by syscall
    localparam logic [IDX_W-1:0] REG_ZERO  = 5'd0;
    localparam logic [IDX_W-1:0] REG_V0    = 5'd2;
    localparam logic [IDX_W-1:0] REG_A0    = 5'd4;

    // syscall numbers held in register 2
    localparam logic [DATA_W-1:0] SYS_PRINT_INT  = 32'd1;
    localparam logic [DATA_W-1:0] SYS_EXIT       = 32'd10;
    localparam logic [DATA_W-1:0] SYS_PRINT_CHAR = 32'd11;

    // syscall event codes
    localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
    localparam logic [EV_W-1:0] EV_PRINT_INT  = 3'd1;
    localparam logic [EV_W-1:0] EV_PRINT_CHAR = 3'd2;
    localparam logic [EV_W-1:0] EV_EXIT       = 3'd3;
    localparam logic [EV_W-1:0] EV_UNKNOWN    = 3'd4;

    localparam logic [DATA_W-1:0] CHAR_MASK = 32'h0000_00ff;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [DATA_W-1:0] wr_val;
        logic              taken;
        logic [DATA_W-1:0] pc;
        logic [EV_W-1:0]   ev;
        logic [DATA_W-1:0] sval;
    } exe_result_t;

endpackage

### rtl/core/mseu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mseu_ram
// Generic single-write, single-read RAM with registered read data.
// A read in the same cycle as a write to the same address returns old data.
// ----------------------------------------------------------------------------
module mseu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/mseu_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mseu_alu
// Combinational execute logic: ALU, branch resolution, syscall decode and
// the register zero write drop.
// ----------------------------------------------------------------------------
module mseu_alu (
    input  logic [mseu_pkg::OP_W-1:0]   op,
    input  logic [mseu_pkg::IDX_W-1:0]  dest_idx,
    input  logic [mseu_pkg::IDX_W-1:0]  tgt_idx,
    input  logic [mseu_pkg::IMM_W-1:0]  imm,
    input  logic [mseu_pkg::DATA_W-1:0] opnd_a,
    input  logic [mseu_pkg::DATA_W-1:0] opnd_b,
    input  logic [mseu_pkg::DATA_W-1:0] pc,
    output mseu_pkg::exe_result_t       result
);

    logic [mseu_pkg::DATA_W-1:0] simm;
    logic [mseu_pkg::DATA_W-1:0] zimm;
    logic [mseu_pkg::DATA_W-1:0] prod;
    logic                        wr;
    logic [mseu_pkg::IDX_W-1:0]  widx;
    logic [mseu_pkg::DATA_W-1:0] wval;
    logic                        taken;
    logic [mseu_pkg::EV_W-1:0]   ev;
    logic [mseu_pkg::DATA_W-1:0] sval;

    assign simm = {{(mseu_pkg::DATA_W - mseu_pkg::IMM_W){imm[mseu_pkg::IMM_W-1]}}, imm};
    assign zimm = {{(mseu_pkg::DATA_W - mseu_pkg::IMM_W){1'b0}}, imm};
    assign prod = opnd_a * opnd_b;

    always_comb
    begin
        wr    = 1'b0;
        widx  = mseu_pkg::REG_ZERO;
        wval  = '0;
        taken = 1'b0;
        ev    = mseu_pkg::EV_NONE;
        sval  = '0;
        unique case (op)
            mseu_pkg::OP_ADD:
            begin
                wr = 1'b1; widx = dest_idx; wval = opnd_a + opnd_b;
            end
            mseu_pkg::OP_SUB:
            begin
                wr = 1'b1; widx = dest_idx; wval = opnd_a - opnd_b;
            end
            mseu_pkg::OP_AND:
            begin
                wr = 1'b1; widx = dest_idx; wval = opnd_a & opnd_b;
            end
            mseu_pkg::OP_OR:
            begin
                wr = 1'b1; widx = dest_idx; wval = opnd_a | opnd_b;
            end
            mseu_pkg::OP_SLT:
            begin
                wr = 1'b1; widx = dest_idx;
                wval = {31'd0, ($signed(opnd_a) < $signed(opnd_b))};
            end
            mseu_pkg::OP_MUL:
            begin
                wr = 1'b1; widx = dest_idx; wval = prod;
            end
            mseu_pkg::OP_BEQ:  taken = (opnd_a == opnd_b);
            mseu_pkg::OP_BNE:  taken = (opnd_a != opnd_b);
            mseu_pkg::OP_ADDI:
            begin
                wr = 1'b1; widx = tgt_idx; wval = opnd_a + simm;
            end
            mseu_pkg::OP_SLTI:
            begin
                wr = 1'b1; widx = tgt_idx;
                wval = {31'd0, ($signed(opnd_a) < $signed(simm))};
            end
            mseu_pkg::OP_ANDI:
            begin
                wr = 1'b1; widx = tgt_idx; wval = opnd_a & zimm;
            end
            mseu_pkg::OP_ORI:
            begin
                wr = 1'b1; widx = tgt_idx; wval = opnd_a | zimm;
            end
            mseu_pkg::OP_LUI:
            begin
                wr = 1'b1; widx = tgt_idx;
                wval = {imm, {(mseu_pkg::DATA_W - mseu_pkg::IMM_W){1'b0}}};
            end
            mseu_pkg::OP_SYSCALL:
            begin
                // operand a carries register 2, operand b register 4
                priority if (opnd_a == mseu_pkg::SYS_PRINT_INT)
                begin
                    ev = mseu_pkg::EV_PRINT_INT; sval = opnd_b;
                end
                else if (opnd_a == mseu_pkg::SYS_EXIT)
                begin
                    ev = mseu_pkg::EV_EXIT;
                end
                else if (opnd_a == mseu_pkg::SYS_PRINT_CHAR)
                begin
                    ev = mseu_pkg::EV_PRINT_CHAR; sval = opnd_b & mseu_pkg::CHAR_MASK;
                end
                else
                begin
                    ev = mseu_pkg::EV_UNKNOWN; sval = opnd_a;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        // drop writes to register zero
        result.wr_en  = wr && (widx != mseu_pkg::REG_ZERO);
        result.wr_idx = result.wr_en ? widx : mseu_pkg::REG_ZERO;
        result.wr_val = result.wr_en ? wval : '0;
        result.taken  = taken;
        result.pc     = taken ? (pc + simm) : pc;
        result.ev     = ev;
        result.sval   = sval;
    end

endmodule

### rtl/core/mips_subset_execute_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_execute_unit_top
// Execute stage for a MIPS32 integer subset: 32 x 32-bit register file,
// program counter, ALU, branches and syscall decode. One result per beat.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  input   | in_valid / in_ready  | op, dest_index, src_index, tgt_index,
//          |                      | immediate
//  output  | out_valid / out_ready| write_enable, write_index, write_value,
//          |                      | branch_taken, pc_value, syscall_event,
//          |                      | syscall_value
//
//  One instruction per clock sustained while out_ready stays high; each result
//  passes through the stage register and then leaves from the result register.
//  Reset clears the program counter and the per-register valid bits, so every
//  register reads as zero until first written; no clearing pass is needed.
//  When the result register is full and not taken, an occupied execute stage
//  holds and in_ready falls; a taken result frees the stage in the same cycle.
//
// Pipeline:
//  accept edge : register file read issued (two RAM copies, registered read);
//                op, indices and immediate captured in the stage register.
//  stage       : operand select (forward from the last write, valid bit
//                check), ALU and branch logic.
//  advance edge: register file and PC written, result register loaded.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit_top (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mseu_pkg::OP_W-1:0]           op,
    input  logic [mseu_pkg::IDX_W-1:0]          dest_index,
    input  logic [mseu_pkg::IDX_W-1:0]          src_index,
    input  logic [mseu_pkg::IDX_W-1:0]          tgt_index,
    input  logic [mseu_pkg::IMM_W-1:0]          immediate,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                write_enable,
    output logic [mseu_pkg::IDX_W-1:0]          write_index,
    output logic signed [mseu_pkg::DATA_W-1:0]  write_value,
    output logic                                branch_taken,
    output logic signed [mseu_pkg::DATA_W-1:0]  pc_value,
    output logic [mseu_pkg::EV_W-1:0]           syscall_event,
    output logic signed [mseu_pkg::DATA_W-1:0]  syscall_value
);

    // handshake
    logic in_accept;
    logic s1_advance;

    // stage register
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [mseu_pkg::OP_W-1:0]   s1_op_reg;
    logic [mseu_pkg::IDX_W-1:0]  s1_dest_reg;
    logic [mseu_pkg::IDX_W-1:0]  s1_a_idx_reg;
    logic [mseu_pkg::IDX_W-1:0]  s1_b_idx_reg;
    logic [mseu_pkg::IMM_W-1:0]  s1_imm_reg;

    // register file read
    logic [mseu_pkg::IDX_W-1:0]  rd_a_idx;
    logic [mseu_pkg::IDX_W-1:0]  rd_b_idx;
    logic [mseu_pkg::DATA_W-1:0] ram_a_data;
    logic [mseu_pkg::DATA_W-1:0] ram_b_data;
    logic [mseu_pkg::NUM_REGS-1:0] reg_valid_reg;
    logic [mseu_pkg::NUM_REGS-1:0] reg_valid_next;

    // last write, for forwarding into the stage
    logic                        fwd_en_reg;
    logic [mseu_pkg::IDX_W-1:0]  fwd_idx_reg;
    logic [mseu_pkg::DATA_W-1:0] fwd_val_reg;

    logic [mseu_pkg::DATA_W-1:0] opnd_a;
    logic [mseu_pkg::DATA_W-1:0] opnd_b;

    logic [mseu_pkg::DATA_W-1:0] pc_reg;

    mseu_pkg::exe_result_t       exe_res;
    mseu_pkg::exe_result_t       res_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    // ---------------------------------------------------------------------
    // Handshake: an occupied stage advances whenever the result register is
    // free or being emptied; a new beat enters when the stage is empty or moves on.
    // ---------------------------------------------------------------------
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    // Syscall reads registers 2 and 4 instead of the named sources
    assign rd_a_idx = (op == mseu_pkg::OP_SYSCALL) ? mseu_pkg::REG_V0 : src_index;
    assign rd_b_idx = (op == mseu_pkg::OP_SYSCALL) ? mseu_pkg::REG_A0 : tgt_index;

    // Two identical copies of the register file, one per read port
    mseu_ram #(
        .WIDTH (mseu_pkg::DATA_W),
        .DEPTH (mseu_pkg::NUM_REGS)
    ) u_rf_a (
        .clk     (clk),
        .wr_en   (s1_advance && exe_res.wr_en),
        .wr_addr (exe_res.wr_idx),
        .wr_data (exe_res.wr_val),
        .rd_en   (in_accept),
        .rd_addr (rd_a_idx),
        .rd_data (ram_a_data)
    );

    mseu_ram #(
        .WIDTH (mseu_pkg::DATA_W),
        .DEPTH (mseu_pkg::NUM_REGS)
    ) u_rf_b (
        .clk     (clk),
        .wr_en   (s1_advance && exe_res.wr_en),
        .wr_addr (exe_res.wr_idx),
        .wr_data (exe_res.wr_val),
        .rd_en   (in_accept),
        .rd_addr (rd_b_idx),
        .rd_data (ram_b_data)
    );

    // ---------------------------------------------------------------------
    // Operand select. The RAM read happens at the accept edge, which may be
    // the very edge at which the previous instruction writes; that write is
    // held in the forwarding register and takes priority. Any write before it
    // already landed in the RAM, and the forwarded copy then matches it.
    // Registers never written read as zero through their valid bit.
    // ---------------------------------------------------------------------
    always_comb
    begin
        if (fwd_en_reg && (fwd_idx_reg == s1_a_idx_reg))
        begin
            opnd_a = fwd_val_reg;
        end
        else
        begin
            opnd_a = reg_valid_reg[s1_a_idx_reg] ? ram_a_data : '0;
        end

        if (fwd_en_reg && (fwd_idx_reg == s1_b_idx_reg))
        begin
            opnd_b = fwd_val_reg;
        end
        else
        begin
            opnd_b = reg_valid_reg[s1_b_idx_reg] ? ram_b_data : '0;
        end
    end

    // The b index doubles as the immediate-form destination; syscall never
    // writes, so its substituted index is harmless.
    mseu_alu u_alu (
        .op       (s1_op_reg),
        .dest_idx (s1_dest_reg),
        .tgt_idx  (s1_b_idx_reg),
        .imm      (s1_imm_reg),
        .opnd_a   (opnd_a),
        .opnd_b   (opnd_b),
        .pc       (pc_reg),
        .result   (exe_res)
    );

    // ---------------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next = in_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);

        priority if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        reg_valid_next = reg_valid_reg;
        if (s1_advance && exe_res.wr_en)
        begin
            reg_valid_next[exe_res.wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            reg_valid_reg <= '0;
            fwd_en_reg    <= 1'b0;
            pc_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            reg_valid_reg <= reg_valid_next;
            if (s1_advance)
            begin
                // hold the last real write for forwarding
                if (exe_res.wr_en)
                begin
                    fwd_en_reg <= 1'b1;
                end
                pc_reg <= exe_res.pc;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg    <= op;
            s1_dest_reg  <= dest_index;
            s1_a_idx_reg <= rd_a_idx;
            s1_b_idx_reg <= rd_b_idx;
            s1_imm_reg   <= immediate;
        end
        if (s1_advance)
        begin
            res_reg <= exe_res;
            if (exe_res.wr_en)
            begin
                fwd_idx_reg <= exe_res.wr_idx;
                fwd_val_reg <= exe_res.wr_val;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------------
    assign out_valid     = out_valid_reg;
    assign write_enable  = res_reg.wr_en;
    assign write_index   = res_reg.wr_idx;
    assign write_value   = $signed(res_reg.wr_val);
    assign branch_taken  = res_reg.taken;
    assign pc_value      = $signed(res_reg.pc);
    assign syscall_event = res_reg.ev;
    assign syscall_value = $signed(res_reg.sval);

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MIPS subset execute unit. A queue of
// instructions, directed corner cases first and then random programmes, feeds
// a valid/ready driver. A behavioural model of the register file and PC
// predicts every result beat, and the monitor checks each one field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned DATA_W   = mseu_pkg::DATA_W;
    localparam int unsigned IDX_W    = mseu_pkg::IDX_W;
    localparam int unsigned OP_W     = mseu_pkg::OP_W;
    localparam int unsigned IMM_W    = mseu_pkg::IMM_W;
    localparam int unsigned EV_W     = mseu_pkg::EV_W;
    localparam int unsigned NUM_REGS = mseu_pkg::NUM_REGS;

    typedef mseu_pkg::exe_result_t exe_result_t;

    // Opcodes outside the decoded subset: the unit treats them as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd14;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

    localparam int RANDOM_INSTRS = 810;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [IDX_W-1:0] rd;
        logic [IDX_W-1:0] rs;
        logic [IDX_W-1:0] rt;
        logic [IMM_W-1:0] imm;
    } instr_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input is known from time zero.
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic [OP_W-1:0]          op         = '0;
    logic [IDX_W-1:0]         dest_index = '0;
    logic [IDX_W-1:0]         src_index  = '0;
    logic [IDX_W-1:0]         tgt_index  = '0;
    logic [IMM_W-1:0]         immediate  = '0;

    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic                     write_enable;
    logic [IDX_W-1:0]         write_index;
    logic signed [DATA_W-1:0] write_value;
    logic                     branch_taken;
    logic signed [DATA_W-1:0] pc_value;
    logic [EV_W-1:0]          syscall_event;
    logic signed [DATA_W-1:0] syscall_value;

    always #6 clk = ~clk;

    mips_subset_execute_unit_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .dest_index    (dest_index),
        .src_index     (src_index),
        .tgt_index     (tgt_index),
        .immediate     (immediate),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_enable  (write_enable),
        .write_index   (write_index),
        .write_value   (write_value),
        .branch_taken  (branch_taken),
        .pc_value      (pc_value),
        .syscall_event (syscall_event),
        .syscall_value (syscall_value)
    );

    // ------------------------------------------------------------------
    // Architectural model: our own copy of the register file and the PC.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] arch_regs [NUM_REGS];
    logic [DATA_W-1:0] arch_pc;

    instr_t      pending_instrs [$];
    exe_result_t expected_results [$];

    int total_instrs   = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int mismatch_count = 0;

    // Retire one instruction against the model and return the beat that the
    // unit should emit for it.
    function automatic exe_result_t execute_instruction(input instr_t ins);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] simm;
        logic [DATA_W-1:0] zimm;
        logic [DATA_W-1:0] sel;
        exe_result_t       res;
        a    = arch_regs[ins.rs];
        b    = arch_regs[ins.rt];
        simm = {{(DATA_W-IMM_W){ins.imm[IMM_W-1]}}, ins.imm};
        zimm = {{(DATA_W-IMM_W){1'b0}}, ins.imm};
        res  = '0;
        res.ev = mseu_pkg::EV_NONE;
        case (ins.opcode)
            mseu_pkg::OP_ADD:
            begin
                res.wr_en = 1'b1; res.wr_idx = ins.rd; res.wr_val = a + b;
            end
            mseu_pkg::OP_SUB:
            begin
                res.wr_en = 1'b1; res.wr_idx = ins.rd; res.wr_val = a - b;
            end
            mseu_pkg::OP_AND:
            begin
                res.wr_en = 1'b1; res.wr_idx = ins.rd; res.wr_val = a & b;
            end
            mseu_pkg::OP_OR:
            begin
                res.wr_en = 1'b1; res.wr_idx = ins.rd; res.wr_val = a | b;
            end
            mseu_pkg::OP_SLT:
            begin
                res.wr_en  = 1'b1;
                res.wr_idx = ins.rd;
                res.wr_val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            end
            mseu_pkg::OP_MUL:
            begin
                res.wr_en = 1'b1; res.wr_idx = ins.rd; res.wr_val = a * b;
            end
            mseu_pkg::OP_BEQ:  res.taken = (a == b);
            mseu_pkg::OP_BNE:  res.taken = (a != b);
            mseu_pkg::OP_ADDI:
            begin
                res.wr_en = 1'b1; res.wr_idx = ins.rt; res.wr_val = a + simm;
            end
            mseu_pkg::OP_SLTI:
            begin
                res.wr_en  = 1'b1;
                res.wr_idx = ins.rt;
                res.wr_val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
            end
            mseu_pkg::OP_ANDI:
            begin
                res.wr_en = 1'b1; res.wr_idx = ins.rt; res.wr_val = a & zimm;
            end
            mseu_pkg::OP_ORI:
            begin
                res.wr_en = 1'b1; res.wr_idx = ins.rt; res.wr_val = a | zimm;
            end
            mseu_pkg::OP_LUI:
            begin
                res.wr_en = 1'b1; res.wr_idx = ins.rt; res.wr_val = {ins.imm, 16'h0};
            end
            mseu_pkg::OP_SYSCALL:
            begin
                sel = arch_regs[mseu_pkg::REG_V0];
                if (sel == mseu_pkg::SYS_PRINT_INT)
                begin
                    res.ev   = mseu_pkg::EV_PRINT_INT;
                    res.sval = arch_regs[mseu_pkg::REG_A0];
                end
                else if (sel == mseu_pkg::SYS_EXIT)
                begin
                    res.ev = mseu_pkg::EV_EXIT;
                end
                else if (sel == mseu_pkg::SYS_PRINT_CHAR)
                begin
                    res.ev   = mseu_pkg::EV_PRINT_CHAR;
                    res.sval = arch_regs[mseu_pkg::REG_A0] & mseu_pkg::CHAR_MASK;
                end
                else
                begin
                    res.ev   = mseu_pkg::EV_UNKNOWN;
                    res.sval = sel;
                end
            end
            default: ;
        endcase
        // Register zero is hardwired: drop the write and blank the fields.
        if (res.wr_en && res.wr_idx == mseu_pkg::REG_ZERO)
        begin
            res.wr_en  = 1'b0;
            res.wr_val = '0;
        end
        if (res.wr_en)
            arch_regs[res.wr_idx] = res.wr_val;
        else
            res.wr_idx = '0;
        if (res.taken)
            arch_pc = arch_pc + simm;
        res.pc = arch_pc;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic push_instr(input logic [OP_W-1:0] opc, input logic [IDX_W-1:0] rd,
                              input logic [IDX_W-1:0] rs, input logic [IDX_W-1:0] rt,
                              input logic [IMM_W-1:0] imm);
        instr_t ins;
        ins.opcode = opc;
        ins.rd     = rd;
        ins.rs     = rs;
        ins.rt     = rt;
        ins.imm    = imm;
        pending_instrs.push_back(ins);
    endtask

    // Favour the low registers so that back-to-back dependencies are common.
    function automatic logic [IDX_W-1:0] pick_reg();
        if ($urandom_range(1) == 0)
            return IDX_W'($urandom_range(7));
        return IDX_W'($urandom_range(NUM_REGS - 1));
    endfunction

    function automatic logic [IMM_W-1:0] pick_imm();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return ($urandom_range(1) == 0) ? 16'h8000 : 16'h7fff;
            default: return IMM_W'($urandom);
        endcase
    endfunction

    // Idle length in cycles: mostly none or short, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // ------------------------------------------------------------------
    // Programme: directed corner cases, then random instructions.
    // ------------------------------------------------------------------
    initial
    begin
        int                n;
        int                kind;
        logic [IMM_W-1:0]  sys_num;
        for (n = 0; n < NUM_REGS; n++)
            arch_regs[n] = '0;
        arch_pc = '0;

        // Build the extreme operands: r1 = most negative, r3 = -1, r6 = most positive.
        push_instr(mseu_pkg::OP_LUI,  5'd0, mseu_pkg::REG_ZERO, 5'd1, 16'h8000);
        push_instr(mseu_pkg::OP_ADDI, 5'd0, mseu_pkg::REG_ZERO, 5'd3, 16'hffff);
        push_instr(mseu_pkg::OP_LUI,  5'd0, mseu_pkg::REG_ZERO, 5'd6, 16'h7fff);
        push_instr(mseu_pkg::OP_ORI,  5'd0, 5'd6,               5'd6, 16'hffff);
        // Wrapping arithmetic and the logic operations.
        push_instr(mseu_pkg::OP_ADD,  5'd7,  5'd6, 5'd6, 16'h0000);
        push_instr(mseu_pkg::OP_SUB,  5'd8,  5'd1, 5'd6, 16'h0000);
        push_instr(mseu_pkg::OP_AND,  5'd9,  5'd1, 5'd3, 16'h0000);
        push_instr(mseu_pkg::OP_OR,   5'd10, 5'd1, 5'd6, 16'h0000);
        // Signed compares across the sign boundary.
        push_instr(mseu_pkg::OP_SLT,  5'd11, 5'd1, 5'd6, 16'h0000);
        push_instr(mseu_pkg::OP_SLTI, 5'd0,  5'd1, 5'd12, 16'hffff);
        // Only the low word of the product survives.
        push_instr(mseu_pkg::OP_MUL,  5'd13, 5'd6, 5'd6, 16'h0000);
        // Writes to register zero are dropped.
        push_instr(mseu_pkg::OP_ADDI, 5'd0, 5'd3, mseu_pkg::REG_ZERO, 16'h0005);
        push_instr(mseu_pkg::OP_ADD,  mseu_pkg::REG_ZERO, 5'd6, 5'd6, 16'h0000);
        // Zero-extended immediates.
        push_instr(mseu_pkg::OP_ANDI, 5'd0, 5'd3,               5'd14, 16'hffff);
        push_instr(mseu_pkg::OP_ORI,  5'd0, mseu_pkg::REG_ZERO, 5'd15, 16'h8000);
        // Branches, taken with negative and positive offsets, and not taken.
        push_instr(mseu_pkg::OP_BEQ, 5'd0, mseu_pkg::REG_ZERO, mseu_pkg::REG_ZERO,
                   16'hfffc);
        push_instr(mseu_pkg::OP_BEQ, 5'd0, 5'd1, 5'd3, 16'h0010);
        push_instr(mseu_pkg::OP_BNE, 5'd0, 5'd1, 5'd3, 16'h7fff);
        push_instr(mseu_pkg::OP_BNE, 5'd0, 5'd3, 5'd3, 16'h8000);
        // Every syscall flavour, with a0 = -1 so the character mask shows.
        push_instr(mseu_pkg::OP_ADDI, 5'd0, 5'd3, mseu_pkg::REG_A0, 16'h0000);
        push_instr(mseu_pkg::OP_ADDI, 5'd0, mseu_pkg::REG_ZERO, mseu_pkg::REG_V0,
                   mseu_pkg::SYS_PRINT_INT[IMM_W-1:0]);
        push_instr(mseu_pkg::OP_SYSCALL, 5'd0, 5'd0, 5'd0, 16'h0000);
        push_instr(mseu_pkg::OP_ADDI, 5'd0, mseu_pkg::REG_ZERO, mseu_pkg::REG_V0,
                   mseu_pkg::SYS_PRINT_CHAR[IMM_W-1:0]);
        push_instr(mseu_pkg::OP_SYSCALL, 5'd0, 5'd0, 5'd0, 16'h0000);
        push_instr(mseu_pkg::OP_ADDI, 5'd0, mseu_pkg::REG_ZERO, mseu_pkg::REG_V0,
                   mseu_pkg::SYS_EXIT[IMM_W-1:0]);
        push_instr(mseu_pkg::OP_SYSCALL, 5'd0, 5'd0, 5'd0, 16'h0000);
        push_instr(mseu_pkg::OP_ADDI, 5'd0, mseu_pkg::REG_ZERO, mseu_pkg::REG_V0,
                   16'h8000);
        push_instr(mseu_pkg::OP_SYSCALL, 5'd0, 5'd0, 5'd0, 16'h0000);
        // Spare opcodes do nothing.
        push_instr(OP_SPARE_LO, 5'd9, 5'd1, 5'd6, 16'hffff);
        push_instr(OP_SPARE_HI, 5'd9, 5'd1, 5'd6, 16'hffff);

        // Random part: mostly ordinary instructions, with syscalls usually
        // preceded by a load of the call number so every call type is hit.
        for (n = 0; n < RANDOM_INSTRS; n++)
        begin
            kind = $urandom_range(99);
            if (kind < 8)
            begin
                case ($urandom_range(3))
                    0:       sys_num = mseu_pkg::SYS_PRINT_INT[IMM_W-1:0];
                    1:       sys_num = mseu_pkg::SYS_EXIT[IMM_W-1:0];
                    2:       sys_num = mseu_pkg::SYS_PRINT_CHAR[IMM_W-1:0];
                    default: sys_num = IMM_W'($urandom);
                endcase
                push_instr(mseu_pkg::OP_ADDI, pick_reg(), mseu_pkg::REG_ZERO,
                           mseu_pkg::REG_V0, sys_num);
                push_instr(mseu_pkg::OP_SYSCALL, pick_reg(), pick_reg(), pick_reg(),
                           pick_imm());
            end
            else if (kind < 12)
            begin
                push_instr((kind < 10) ? OP_SPARE_LO : OP_SPARE_HI,
                           pick_reg(), pick_reg(), pick_reg(), pick_imm());
            end
            else
            begin
                push_instr(OP_W'($urandom_range(mseu_pkg::OP_SYSCALL)),
                           pick_reg(), pick_reg(), pick_reg(), pick_imm());
            end
        end
        total_instrs = pending_instrs.size();

        // Hold reset, then release it on a falling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every beat to be accepted and answered, then let the pipe
        // drain a few cycles so a stray extra result would still be caught.
        wait (accepted_count == total_instrs && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("mips_subset_execute_unit_top regression: pass");
        else
            $display("mips_subset_execute_unit_top regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with every long stall.
    initial
    begin
        #20_000_000;
        $display("mips_subset_execute_unit_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver: changes on the falling edge. Hold valid and payload
    // until the beat is taken; insert random gaps between beats, with the
    // odd burst of back-to-back beats.
    // ------------------------------------------------------------------
    logic   in_fire = 1'b0;
    int     in_gap  = 0;
    int     in_calm = 0;
    instr_t drive_instr;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_instrs.size() > 0)
            begin
                drive_instr = pending_instrs.pop_front();
                in_valid   <= 1'b1;
                op         <= drive_instr.opcode;
                dest_index <= drive_instr.rd;
                src_index  <= drive_instr.rs;
                tgt_index  <= drive_instr.rt;
                immediate  <= drive_instr.imm;
                if (in_calm > 0)
                begin
                    in_calm--;
                end
                else
                begin
                    in_gap = pick_idle();
                    if ($urandom_range(39) == 0)
                        in_calm = $urandom_range(80, 30);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output back-pressure: drop ready for random stretches, with some
    // stretches of steady ready.
    // ------------------------------------------------------------------
    int out_stall = 0;
    int out_calm  = 0;

    always @(negedge clk)
    begin
        if (out_calm > 0)
        begin
            out_calm--;
            out_ready <= 1'b1;
        end
        else if (out_stall > 0)
        begin
            out_stall--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            out_stall = pick_idle();
            if ($urandom_range(39) == 0)
                out_calm = $urandom_range(80, 30);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, predict accepted input beats and check
    // result beats against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("result %0d, %s: expected 0x%08h, got 0x%08h",
                         result_count, field, want, got);
        end
    endtask

    instr_t      seen_instr;
    exe_result_t want_result;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                seen_instr.opcode = op;
                seen_instr.rd     = dest_index;
                seen_instr.rs     = src_index;
                seen_instr.rt     = tgt_index;
                seen_instr.imm    = immediate;
                expected_results.push_back(execute_instruction(seen_instr));
                accepted_count++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result %0d arrived with no instruction outstanding",
                                 result_count);
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    check_field("write_enable",  DATA_W'(want_result.wr_en),  DATA_W'(write_enable));
                    check_field("write_index",   DATA_W'(want_result.wr_idx), DATA_W'(write_index));
                    check_field("write_value",   want_result.wr_val,          write_value);
                    check_field("branch_taken",  DATA_W'(want_result.taken),  DATA_W'(branch_taken));
                    check_field("pc_value",      want_result.pc,              pc_value);
                    check_field("syscall_event", DATA_W'(want_result.ev),     DATA_W'(syscall_event));
                    check_field("syscall_value", want_result.sval,            syscall_value);
                end
                result_count++;
            end
        end
    end

endmodule

### sim.f
rtl/core/mseu_pkg.sv
rtl/core/mseu_ram.sv
rtl/core/mseu_alu.sv
rtl/core/mips_subset_execute_unit_top.sv
dv/testbench.sv
